// File: hdl/rgbpng_pkg.sv
// Shared types, constants and helper functions for the PNG stream encoder.
// No dependencies; compile first.
`default_nettype none

package rgbpng_pkg;

  localparam int PIXEL_W    = 32;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_e;

  localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RST  = 13'd1920;
  localparam logic [CFG_DATA_W-1:0] IMAGE_HEIGHT_RST = 13'd1080;

  localparam logic [31:0] CRC32_POLY = 32'hEDB88320;
  localparam logic [16:0] ADLER_MOD  = 17'd65521;
  localparam logic [15:0] BLOCK_MAX  = 16'hFFFF;

  // File framing bytes
  localparam logic [63:0] PNG_SIG      = 64'h89504E470D0A1A0A;
  localparam logic [31:0] TAG_IHDR     = 32'h49484452;
  localparam logic [31:0] TAG_IDAT     = 32'h49444154;
  localparam logic [31:0] TAG_IEND     = 32'h49454E44;
  localparam logic [7:0]  IHDR_LEN     = 8'd13;
  localparam logic [7:0]  BIT_DEPTH    = 8'd8;
  localparam logic [7:0]  COLOR_RGB    = 8'd2;
  localparam logic [7:0]  ZLIB_CMF     = 8'h78;
  localparam logic [7:0]  ZLIB_FLG     = 8'h01;
  // zlib header plus Adler-32 trailer
  localparam logic [31:0] ZLIB_FRAMING = 32'd6;

  // Update request for the CRC-32 and Adler-32 accumulators
  typedef struct packed {
    logic              crc_feed;
    logic              crc_init;
    logic              adler_feed;
    logic              adler_clear;
    logic [BYTE_W-1:0] data;
  } sums_ctrl_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'h0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC32_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  // Byte of a 32-bit word in big-endian order, position 0 is the top byte
  function automatic logic [7:0] be_byte(input logic [31:0] word,
                                         input logic [1:0]  pos);
    return word[31 - 8*pos -: 8];
  endfunction

endpackage

`default_nettype wire

// File: hdl/rgbpng_if.sv
// Channel interfaces of the PNG stream encoder: pixel in, file byte out, config write.
// Depends on rgbpng_pkg.
`default_nettype none

interface rgbpng_pixel_if import rgbpng_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_word;

  modport source (output valid, output pixel_word, input ready);
  modport sink   (input valid, input pixel_word, output ready);
endinterface

interface rgbpng_byte_if import rgbpng_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              run_last;
  logic              file_end;

  modport source (output valid, output out_byte, output run_last, output file_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input file_end,
                  output ready);
endinterface

interface rgbpng_cfg_if import rgbpng_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

`default_nettype wire

// File: hdl/rgb_frame_to_stored_png_stream_core.sv
// Top level: XRGB pixel stream in, uncompressed PNG file (stored deflate) out.
// Depends on rgbpng_pkg, rgbpng_if (channel interfaces) and rgbpng_sums.
//
//   channel   dir   payload                              request taken when
//   pixel_i   in    pixel_word[31:0]                     valid && ready
//   png_o     out   out_byte[7:0], run_last, file_end    valid && ready
//   cfg_i     in    reg_index[1:0], reg_data[12:0]       valid (ready tied high)
//
// One file byte leaves per cycle through the output register while png_o is ready;
// a pixel issues 3 bytes: 4 on the first pixel of a row (filter byte), 5 more where a
// stored block begins, 43 more on the first pixel of a frame, 20 more on the last.
// The next pixel request is taken in the cycle that the current pixel's last byte
// is issued.
// Reset clears all control state and returns the registers to 1920 x 1080.
// A stall on png_o freezes the byte sequencer; the pixel register holds its request.
`default_nettype none

module rgb_frame_to_stored_png_stream_core import rgbpng_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rgbpng_pixel_if.sink pixel_i,
  rgbpng_byte_if.source png_o,
  rgbpng_cfg_if.sink   cfg_i
);

  // Widths of the latched frame size, the position counters and the raw byte count
  localparam int FW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int RAW_W = $clog2((3 * MAX_WIDTH + 1) * MAX_HEIGHT + 1);
  // Width for the block count division, at least one bit above the low 16
  localparam int MW    = (RAW_W + 1 > 17) ? RAW_W + 1 : 17;
  localparam int QW    = MW - 16;

  localparam logic [5:0] HEAD_LAST = 6'd42;
  localparam logic [5:0] TAIL_LAST = 6'd19;
  localparam logic [2:0] BH_LAST   = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_HEAD = 4'b0010,
    ST_RAW  = 4'b0100,
    ST_TAIL = 4'b1000
  } state_e;

  // Which byte of the pixel is next; the top byte of the stored word is zero
  typedef enum logic [1:0] {
    SEL_FILTER = 2'd0,
    SEL_RED    = 2'd1,
    SEL_GREEN  = 2'd2,
    SEL_BLUE   = 2'd3
  } raw_sel_e;

  // Control state
  state_e                state_q, state_d;
  logic [5:0]            idx_q, idx_d;        // byte index in frame head or tail
  raw_sel_e              sel_q, sel_d;
  logic [2:0]            bh_q, bh_d;          // byte index in a stored block header
  logic                  open_q, open_d;
  logic [COL_W-1:0]      col_q, col_d;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [15:0]           blk_left_q, blk_left_d;
  logic [RAW_W-1:0]      raw_left_q, raw_left_d;
  logic [FW-1:0]         fw_q, fw_d;
  logic [HW-1:0]         fh_q, fh_d;
  logic [CFG_DATA_W-1:0] cfg_w_q, cfg_h_q;
  logic                  out_valid_q;

  // Payload
  logic [23:0]           px_q, px_d;
  logic [RAW_W-1:0]      raw_n_q;
  logic [QW:0]           blocks_q;
  logic [31:0]           idat_len_q;
  logic [BYTE_W-1:0]     out_byte_q;
  logic                  run_last_q, file_end_q;

  // Datapath
  logic                  adv, in_accept, pix_done, file_end_c;
  logic [BYTE_W-1:0]     byte_c;
  sums_ctrl_t            sums_ctrl;
  logic [31:0]           crc_fin;
  logic [15:0]           adler_lo, adler_hi;
  logic                  raw_big;
  logic [15:0]           blk_len, blk_nlen;
  logic [FW-1:0]         col_inc;
  logic [HW-1:0]         row_inc;
  logic [FW-1:0]         fw_sat;
  logic [HW-1:0]         fh_sat;
  logic [RAW_W-1:0]      raw_n_d;
  logic [MW-1:0]         div_m;
  logic [16:0]           div_r;
  logic [QW:0]           blocks_d;
  logic [31:0]           idat_len_d;

  rgbpng_sums u_sums (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (sums_ctrl),
    .crc_fin_o  (crc_fin),
    .adler_lo_o (adler_lo),
    .adler_hi_o (adler_hi)
  );

  // Issue a byte whenever a pixel is in work and the output register is free
  assign adv          = (state_q != ST_IDLE) && (!out_valid_q || png_o.ready);
  assign pixel_i.ready = (state_q == ST_IDLE) || (adv && pix_done);
  assign in_accept    = pixel_i.valid && pixel_i.ready;
  assign cfg_i.ready  = 1'b1;

  // Saturate the frame size at frame start
  always_comb begin
    if (cfg_w_q < 13'd2) begin
      fw_sat = FW'(2);
    end else if (32'(cfg_w_q) > MAX_WIDTH) begin
      fw_sat = FW'(MAX_WIDTH);
    end else begin
      fw_sat = FW'(cfg_w_q);
    end
    if (cfg_h_q < 13'd1) begin
      fh_sat = HW'(1);
    end else if (32'(cfg_h_q) > MAX_HEIGHT) begin
      fh_sat = HW'(MAX_HEIGHT);
    end else begin
      fh_sat = HW'(cfg_h_q);
    end
  end

  // IDAT length: raw count, then blocks = ceil(raw / 65535), then total.
  // Each stage is registered and settles after the frame size latch, long before
  // the length bytes go out.
  always_comb begin
    raw_n_d  = (RAW_W'(fw_q) + RAW_W'(fw_q) + RAW_W'(fw_q) + RAW_W'(1)) * RAW_W'(fh_q);
    // floor(m / 65535) = (m >> 16) plus one when the low half plus the quotient wraps
    div_m    = MW'(raw_n_q) + MW'(BLOCK_MAX - 16'd1);
    div_r    = 17'(div_m[15:0]) + 17'(div_m[MW-1:16]);
    blocks_d = (QW+1)'(div_m[MW-1:16]) + (QW+1)'(div_r >= 17'(BLOCK_MAX));
    idat_len_d = 32'(raw_n_q) + (32'(blocks_q) << 2) + 32'(blocks_q) + ZLIB_FRAMING;
  end

  // Stored block header fields
  always_comb begin
    raw_big  = 32'(raw_left_q) > 32'(BLOCK_MAX);
    blk_len  = raw_big ? BLOCK_MAX : 16'(raw_left_q);
    blk_nlen = ~blk_len;
  end

  assign col_inc = FW'(col_q) + FW'(1);
  assign row_inc = HW'(row_q) + HW'(1);

  // Byte sequencer
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    sel_d      = sel_q;
    bh_d       = bh_q;
    open_d     = open_q;
    col_d      = col_q;
    row_d      = row_q;
    blk_left_d = blk_left_q;
    raw_left_d = raw_left_q;
    fw_d       = fw_q;
    fh_d       = fh_q;
    px_d       = px_q;
    byte_c     = '0;
    pix_done   = 1'b0;
    file_end_c = 1'b0;
    sums_ctrl  = '0;

    if (adv) begin
      unique case (state_q)
        ST_HEAD: begin
          idx_d = idx_q + 6'd1;
          case (idx_q) inside
            [6'd0:6'd7]:   byte_c = PNG_SIG[63 - 8*idx_q[2:0] -: 8];
            [6'd8:6'd10]:  byte_c = 8'h00;
            6'd11:         byte_c = IHDR_LEN;
            [6'd12:6'd15]: begin
              byte_c             = be_byte(TAG_IHDR, idx_q[1:0]);
              sums_ctrl.crc_feed = 1'b1;
              sums_ctrl.crc_init = (idx_q == 6'd12);
            end
            [6'd16:6'd19]: begin
              byte_c             = be_byte(32'(fw_q), idx_q[1:0]);
              sums_ctrl.crc_feed = 1'b1;
            end
            [6'd20:6'd23]: begin
              byte_c             = be_byte(32'(fh_q), idx_q[1:0]);
              sums_ctrl.crc_feed = 1'b1;
            end
            6'd24: begin
              byte_c             = BIT_DEPTH;
              sums_ctrl.crc_feed = 1'b1;
            end
            6'd25: begin
              byte_c             = COLOR_RGB;
              sums_ctrl.crc_feed = 1'b1;
            end
            [6'd26:6'd28]: begin
              byte_c             = 8'h00;
              sums_ctrl.crc_feed = 1'b1;
            end
            [6'd29:6'd32]: byte_c = be_byte(crc_fin, 2'(idx_q - 6'd29));
            [6'd33:6'd36]: byte_c = be_byte(idat_len_q, 2'(idx_q - 6'd33));
            [6'd37:6'd40]: begin
              byte_c             = be_byte(TAG_IDAT, 2'(idx_q - 6'd37));
              sums_ctrl.crc_feed = 1'b1;
              sums_ctrl.crc_init = (idx_q == 6'd37);
            end
            6'd41: begin
              byte_c             = ZLIB_CMF;
              sums_ctrl.crc_feed = 1'b1;
            end
            6'd42: begin
              byte_c             = ZLIB_FLG;
              sums_ctrl.crc_feed = 1'b1;
            end
            default: byte_c = 8'h00;
          endcase
          // Latch the frame size on the first signature byte
          if (idx_q == 6'd0) begin
            fw_d                  = fw_sat;
            fh_d                  = fh_sat;
            sums_ctrl.adler_clear = 1'b1;
          end
          if (idx_q == HEAD_LAST) begin
            state_d    = ST_RAW;
            sel_d      = SEL_FILTER;
            bh_d       = '0;
            raw_left_d = raw_n_q;
            blk_left_d = '0;
            col_d      = '0;
            row_d      = '0;
            open_d     = 1'b1;
          end
        end

        ST_RAW: begin
          sums_ctrl.crc_feed = 1'b1;
          if (blk_left_q == 16'd0) begin
            // Stored block header: BFINAL, LEN, NLEN
            case (bh_q)
              3'd0:    byte_c = {7'b0, !raw_big};
              3'd1:    byte_c = blk_len[7:0];
              3'd2:    byte_c = blk_len[15:8];
              3'd3:    byte_c = blk_nlen[7:0];
              3'd4:    byte_c = blk_nlen[15:8];
              default: byte_c = 8'h00;
            endcase
            if (bh_q == BH_LAST) begin
              bh_d       = '0;
              blk_left_d = blk_len;
            end else begin
              bh_d = bh_q + 3'd1;
            end
          end else begin
            byte_c               = be_byte(32'(px_q), sel_q);
            sums_ctrl.adler_feed = 1'b1;
            blk_left_d           = blk_left_q - 16'd1;
            raw_left_d           = raw_left_q - RAW_W'(1);
            if (sel_q == SEL_BLUE) begin
              if (col_inc == fw_q) begin
                col_d = '0;
                if (row_inc == fh_q) begin
                  row_d   = '0;
                  state_d = ST_TAIL;
                  idx_d   = '0;
                end else begin
                  row_d    = ROW_W'(row_inc);
                  pix_done = 1'b1;
                end
              end else begin
                col_d    = COL_W'(col_inc);
                pix_done = 1'b1;
              end
            end else begin
              sel_d = raw_sel_e'(sel_q + 2'd1);
            end
          end
        end

        ST_TAIL: begin
          idx_d = idx_q + 6'd1;
          case (idx_q) inside
            [6'd0:6'd3]: begin
              byte_c             = be_byte({adler_hi, adler_lo}, idx_q[1:0]);
              sums_ctrl.crc_feed = 1'b1;
            end
            [6'd4:6'd7]:   byte_c = be_byte(crc_fin, idx_q[1:0]);
            [6'd8:6'd11]:  byte_c = 8'h00;
            [6'd12:6'd15]: begin
              byte_c             = be_byte(TAG_IEND, idx_q[1:0]);
              sums_ctrl.crc_feed = 1'b1;
              sums_ctrl.crc_init = (idx_q == 6'd12);
            end
            [6'd16:6'd19]: byte_c = be_byte(crc_fin, idx_q[1:0]);
            default:       byte_c = 8'h00;
          endcase
          if (idx_q == TAIL_LAST) begin
            file_end_c = 1'b1;
            pix_done   = 1'b1;
            open_d     = 1'b0;
            raw_left_d = '0;
            blk_left_d = '0;
          end
        end

        default: ;
      endcase
      sums_ctrl.data = byte_c;
    end

    if (pix_done) begin
      state_d = ST_IDLE;
    end
    // Take the next request; a row start opens with the filter byte
    if (in_accept) begin
      px_d    = pixel_i.pixel_word[23:0];
      state_d = open_d ? ST_RAW : ST_HEAD;
      idx_d   = '0;
      sel_d   = (col_d == '0) ? SEL_FILTER : SEL_RED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      sel_q       <= SEL_FILTER;
      bh_q        <= '0;
      open_q      <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      blk_left_q  <= '0;
      raw_left_q  <= '0;
      fw_q        <= FW'(2);
      fh_q        <= HW'(1);
      cfg_w_q     <= IMAGE_WIDTH_RST;
      cfg_h_q     <= IMAGE_HEIGHT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      sel_q      <= sel_d;
      bh_q       <= bh_d;
      open_q     <= open_d;
      col_q      <= col_d;
      row_q      <= row_d;
      blk_left_q <= blk_left_d;
      raw_left_q <= raw_left_d;
      fw_q       <= fw_d;
      fh_q       <= fh_d;
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (png_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        case (cfg_i.reg_index)
          REG_IMAGE_WIDTH:  cfg_w_q <= cfg_i.reg_data;
          REG_IMAGE_HEIGHT: cfg_h_q <= cfg_i.reg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    px_q       <= px_d;
    raw_n_q    <= raw_n_d;
    blocks_q   <= blocks_d;
    idat_len_q <= idat_len_d;
    if (adv) begin
      out_byte_q <= byte_c;
      run_last_q <= pix_done;
      file_end_q <= file_end_c;
    end
  end

  assign png_o.valid    = out_valid_q;
  assign png_o.out_byte = out_byte_q;
  assign png_o.run_last = run_last_q;
  assign png_o.file_end = file_end_q;

endmodule

`default_nettype wire

// File: hdl/rgbpng_sums.sv
// Running CRC-32 of the current chunk and Adler-32 of the raw scanline data.
// Depends on rgbpng_pkg.
`default_nettype none

module rgbpng_sums import rgbpng_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sums_ctrl_t ctrl_i,
  output logic [31:0] crc_fin_o,
  output logic [15:0] adler_lo_o,
  output logic [15:0] adler_hi_o
);

  logic [31:0] crc_q, crc_d, crc_base;
  logic [15:0] lo_q, lo_d, hi_q, hi_d;
  logic [16:0] s1, s2;

  always_comb begin
    crc_base = ctrl_i.crc_init ? '1 : crc_q;
    crc_d    = ctrl_i.crc_feed ? crc32_byte(crc_base, ctrl_i.data) : crc_q;

    // Both sums stay below the modulus, so one subtract suffices
    s1 = 17'(lo_q) + 17'(ctrl_i.data);
    if (s1 >= ADLER_MOD) begin
      s1 = s1 - ADLER_MOD;
    end
    s2 = 17'(hi_q) + s1;
    if (s2 >= ADLER_MOD) begin
      s2 = s2 - ADLER_MOD;
    end

    lo_d = lo_q;
    hi_d = hi_q;
    if (ctrl_i.adler_clear) begin
      lo_d = 16'd1;
      hi_d = 16'd0;
    end else if (ctrl_i.adler_feed) begin
      lo_d = s1[15:0];
      hi_d = s2[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '1;
      lo_q  <= 16'd1;
      hi_q  <= 16'd0;
    end else begin
      crc_q <= crc_d;
      lo_q  <= lo_d;
      hi_q  <= hi_d;
    end
  end

  assign crc_fin_o  = ~crc_q;
  assign adler_lo_o = lo_q;
  assign adler_hi_o = hi_q;

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for rgb_frame_to_stored_png_stream_core: XRGB pixels in, PNG bytes out.
// Depends on rgbpng_pkg, the channel interfaces in rgbpng_if and the core itself.
// Every byte is predicted from the pixels that were taken and compared in order.
module tb import rgbpng_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // Saturation bounds, matching the core's default parameters
  localparam logic [12:0] SAT_MAX_W = 13'd4096;
  localparam logic [12:0] SAT_MAX_H = 13'd4096;

  // Indexes past the register list; writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // Row filter type "none", and the IHDR compression, filter and interlace methods
  localparam logic [7:0] FILTER_NONE  = 8'd0;
  localparam logic [7:0] IHDR_METHOD0 = 8'd0;

  localparam int SETTLE_CYCLES = 16;    // output pipeline depth, with margin
  localparam int HOLD_CYCLES   = 600;   // long receiver hold-off
  localparam int QUIET_LIMIT   = 5000;  // cycles with no request taken anywhere
  localparam int MAX_REPORTS   = 30;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       file_end;
  } png_byte_t;

  logic clk_i;
  logic rst_ni;

  rgbpng_pixel_if pix ();
  rgbpng_byte_if  png ();
  rgbpng_cfg_if   cfg ();

  rgb_frame_to_stored_png_stream_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pixel_i(pix),
    .png_o  (png),
    .cfg_i  (cfg)
  );

  // Pixels waiting to be offered, and file bytes still owed by the core
  logic [31:0] pending_pixels[$];
  png_byte_t   png_expect[$];

  int send_idle_pct;
  int recv_stall_pct;
  logic hold_off;
  logic pressure_go;

  int error_count;
  int pixels_taken;
  int bytes_seen;
  int frames_closed;
  int quiet_cycles;

  // Encoder shadow: register copies and the per-frame running state
  logic [12:0] reg_width, reg_height;
  logic [12:0] frame_w, frame_h;
  logic [12:0] col_cnt, row_cnt;
  logic [31:0] crc_acc;
  logic [15:0] adler_lo, adler_hi;
  logic [15:0] blk_left;
  logic [25:0] raw_left;
  logic        frame_active;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [12:0] sat_width(input logic [12:0] w);
    if (w < 13'd2) return 13'd2;
    if (w > SAT_MAX_W) return SAT_MAX_W;
    return w;
  endfunction

  function automatic logic [12:0] sat_height(input logic [12:0] h);
    if (h == 13'd0) return 13'd1;
    if (h > SAT_MAX_H) return SAT_MAX_H;
    return h;
  endfunction

  // Reflected CRC-32, one input bit folded in per iteration
  function automatic logic [31:0] crc_after(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = c_in;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c = (c >> 1) ^ (fb ? CRC32_POLY : 32'h0);
    end
    return c;
  endfunction

  function automatic logic [31:0] random_pixel();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: r[23:0] = 24'hFFFFFF;
      1: r[23:0] = 24'h000000;
      default: ;
    endcase
    return r;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR %s", msg);
  endtask

  task automatic shadow_reset();
    reg_width    = IMAGE_WIDTH_RST;
    reg_height   = IMAGE_HEIGHT_RST;
    frame_w      = 13'd2;
    frame_h      = 13'd1;
    crc_acc      = '1;
    adler_lo     = 16'd1;
    adler_hi     = 16'd0;
    col_cnt      = '0;
    row_cnt      = '0;
    blk_left     = '0;
    raw_left     = '0;
    frame_active = 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic fin);
    png_byte_t e;
    e.out_byte = b;
    e.run_last = 1'b0;
    e.file_end = fin;
    png_expect.push_back(e);
  endtask

  // Byte inside a chunk body: it enters the chunk CRC
  task automatic push_summed(input logic [7:0] b);
    crc_acc = crc_after(crc_acc, b);
    push_byte(b, 1'b0);
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) push_byte(w[8*i +: 8], 1'b0);
  endtask

  task automatic push_tag(input logic [31:0] tag);
    crc_acc = '1;
    for (int i = 3; i >= 0; i--) push_summed(tag[8*i +: 8]);
  endtask

  task automatic push_crc(input logic fin);
    logic [31:0] c;
    c = ~crc_acc;
    for (int i = 3; i >= 1; i--) push_byte(c[8*i +: 8], 1'b0);
    push_byte(c[7:0], fin);
  endtask

  // One scanline byte; open a stored block first when the previous one is used up
  task automatic push_raw(input logic [7:0] b);
    logic [15:0] len;
    logic [16:0] s1;
    logic [17:0] s2;
    if (blk_left == 16'd0) begin
      len = (raw_left > {10'd0, BLOCK_MAX}) ? BLOCK_MAX : raw_left[15:0];
      push_summed({7'd0, {10'd0, len} == raw_left});
      push_summed(len[7:0]);
      push_summed(len[15:8]);
      push_summed(~len[7:0]);
      push_summed(~len[15:8]);
      blk_left = len;
    end
    push_summed(b);
    s1 = {1'b0, adler_lo} + {9'd0, b};
    if (s1 >= ADLER_MOD) s1 = s1 - ADLER_MOD;
    s2 = {2'b0, adler_hi} + {1'b0, s1};
    if (s2 >= {1'b0, ADLER_MOD}) s2 = s2 - {1'b0, ADLER_MOD};
    adler_lo = s1[15:0];
    adler_hi = s2[15:0];
    if (blk_left != 16'd0) blk_left--;
    if (raw_left != 26'd0) raw_left--;
  endtask

  task automatic open_frame();
    logic [31:0] wide;
    logic [31:0] raw_n;
    logic [31:0] n_blocks;
    frame_w = sat_width(reg_width);
    frame_h = sat_height(reg_height);
    for (int i = 7; i >= 0; i--) push_byte(PNG_SIG[8*i +: 8], 1'b0);
    push_word({24'd0, IHDR_LEN});
    push_tag(TAG_IHDR);
    wide = {19'd0, frame_w};
    for (int i = 3; i >= 0; i--) push_summed(wide[8*i +: 8]);
    wide = {19'd0, frame_h};
    for (int i = 3; i >= 0; i--) push_summed(wide[8*i +: 8]);
    push_summed(BIT_DEPTH);
    push_summed(COLOR_RGB);
    push_summed(IHDR_METHOD0);
    push_summed(IHDR_METHOD0);
    push_summed(IHDR_METHOD0);
    push_crc(1'b0);
    raw_n    = (32'd1 + 32'd3 * {19'd0, frame_w}) * {19'd0, frame_h};
    n_blocks = (raw_n + 32'd65534) / 32'd65535;
    push_word(32'd2 + n_blocks * 32'd5 + raw_n + 32'd4);
    push_tag(TAG_IDAT);
    push_summed(ZLIB_CMF);
    push_summed(ZLIB_FLG);
    raw_left     = raw_n[25:0];
    blk_left     = '0;
    adler_lo     = 16'd1;
    adler_hi     = 16'd0;
    col_cnt      = '0;
    row_cnt      = '0;
    frame_active = 1'b1;
  endtask

  task automatic close_frame();
    push_summed(adler_hi[15:8]);
    push_summed(adler_hi[7:0]);
    push_summed(adler_lo[15:8]);
    push_summed(adler_lo[7:0]);
    push_crc(1'b0);
    push_word(32'd0);
    push_tag(TAG_IEND);
    push_crc(1'b1);
    crc_acc      = '1;
    adler_lo     = 16'd1;
    adler_hi     = 16'd0;
    col_cnt      = '0;
    row_cnt      = '0;
    blk_left     = '0;
    raw_left     = '0;
    frame_active = 1'b0;
    frames_closed++;
  endtask

  // Queue every file byte that one taken pixel causes; flag the last one
  task automatic predict_pixel(input logic [31:0] px);
    png_byte_t tail;
    if (!frame_active) open_frame();
    if (col_cnt == 13'd0) push_raw(FILTER_NONE);
    push_raw(px[23:16]);
    push_raw(px[15:8]);
    push_raw(px[7:0]);
    col_cnt++;
    if (col_cnt >= frame_w) begin
      col_cnt = '0;
      row_cnt++;
      if (row_cnt >= frame_h) close_frame();
    end
    tail = png_expect.pop_back();
    tail.run_last = 1'b1;
    png_expect.push_back(tail);
  endtask

  // Pixel driver: hold a request until it is taken, then predict it and offer the next
  always @(posedge clk_i) begin : pixel_driver
    logic offer;
    if (!rst_ni) begin
      pix.valid <= 1'b0;
    end else if (!(pix.valid && !pix.ready)) begin
      if (pix.valid) begin
        predict_pixel(pix.pixel_word);
        void'(pending_pixels.pop_front());
        pixels_taken++;
      end
      offer = (pending_pixels.size() != 0) && ($urandom_range(1, 100) > send_idle_pct);
      pix.valid <= offer;
      // drive noise on the payload while idle
      pix.pixel_word <= offer ? pending_pixels[0] : $urandom;
    end
  end

  // Byte monitor: compare each taken byte with the oldest one owed, then pick ready
  always @(posedge clk_i) begin : png_monitor
    png_byte_t want;
    if (!rst_ni) begin
      png.ready <= 1'b0;
    end else begin
      if (png.valid && png.ready) begin
        bytes_seen++;
        if (png_expect.size() == 0) begin
          flag_error($sformatf("byte %0d: %02h arrived with nothing owed",
                               bytes_seen, png.out_byte));
        end else begin
          want = png_expect.pop_front();
          if (png.out_byte !== want.out_byte)
            flag_error($sformatf("byte %0d: out_byte %02h, want %02h",
                                 bytes_seen, png.out_byte, want.out_byte));
          if (png.run_last !== want.run_last)
            flag_error($sformatf("byte %0d: run_last %b, want %b",
                                 bytes_seen, png.run_last, want.run_last));
          if (png.file_end !== want.file_end)
            flag_error($sformatf("byte %0d: file_end %b, want %b",
                                 bytes_seen, png.file_end, want.file_end));
        end
      end
      png.ready <= !hold_off && ($urandom_range(1, 100) > recv_stall_pct);
    end
  end

  // Long receiver hold-off: the core fills up and must stall pixel requests
  initial begin : receiver_hold
    hold_off = 1'b0;
    wait (pressure_go);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Count cycles in which no request moves on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (pix.valid && pix.ready) || (png.valid && png.ready) ||
        (cfg.valid && cfg.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
    $display("FAIL rgb_frame_to_stored_png_stream_core");
    $finish;
  end

  // Write one register and mirror it into the shadow; only called while idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [12:0] val);
    @(posedge clk_i);
    cfg.valid     <= 1'b1;
    cfg.reg_index <= idx;
    cfg.reg_data  <= val;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) reg_width = val;
    else if (idx == REG_IMAGE_HEIGHT) reg_height = val;
  endtask

  // Wait until every pixel is taken and every owed byte has arrived, then drain the pipe
  task automatic settle();
    while (pending_pixels.size() != 0 || png_expect.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_random(input int n);
    repeat (n) pending_pixels.push_back(random_pixel());
  endtask

  // Small random frame size, whole frames only, at least 8 pixels per phase
  task automatic random_phase();
    logic [12:0] w, h;
    int frame_px;
    int total;
    w = 13'($urandom_range(0, 6));
    h = 13'($urandom_range(0, 3));
    if ($urandom_range(0, 5) == 0) w = 13'($urandom_range(13, 24));
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    frame_px = int'(sat_width(w)) * int'(sat_height(h));
    total = 0;
    while (total < 8) begin
      queue_random(frame_px);
      total += frame_px;
    end
    settle();
  endtask

  task automatic random_mode(input int send_pct, input int recv_pct, input logic squeeze);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int p = 0; p < 2; p++) begin
      if (squeeze && p == 0) pressure_go = 1'b1;
      random_phase();
    end
  endtask

  initial begin : stimulus
    rst_ni         = 1'b0;
    pix.valid      = 1'b0;
    pix.pixel_word = '0;
    png.ready      = 1'b0;
    cfg.valid      = 1'b0;
    cfg.reg_index  = REG_IMAGE_WIDTH;
    cfg.reg_data   = '0;
    pressure_go    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    error_count    = 0;
    pixels_taken   = 0;
    bytes_seen     = 0;
    frames_closed  = 0;
    shadow_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero width and height saturate to the smallest frame, 2 x 1
    write_reg(REG_IMAGE_WIDTH, 13'd0);
    write_reg(REG_IMAGE_HEIGHT, 13'd0);
    pending_pixels.push_back(32'h0000_0000);
    pending_pixels.push_back(32'hFFFF_FFFF);
    settle();

    // Width of one saturates too; spare-index writes after it must not land anywhere
    write_reg(REG_IMAGE_WIDTH, 13'd1);
    write_reg(REG_IMAGE_HEIGHT, 13'd1);
    write_reg(REG_SPARE_A, 13'h1FFF);
    write_reg(REG_SPARE_B, 13'h0000);
    pending_pixels.push_back(32'hFF00_0000);  // top byte is ignored
    pending_pixels.push_back(32'h00FF_FFFF);
    settle();

    // Two rows: filter byte at each row start, single colors, toggling patterns
    write_reg(REG_IMAGE_WIDTH, 13'd3);
    write_reg(REG_IMAGE_HEIGHT, 13'd2);
    pending_pixels.push_back(32'h00FF_0000);
    pending_pixels.push_back(32'h0000_FF00);
    pending_pixels.push_back(32'h0000_00FF);
    pending_pixels.push_back(32'hAA55_AA55);
    pending_pixels.push_back(32'h55AA_55AA);
    pending_pixels.push_back(32'h1234_5678);
    settle();

    // Random frames under each idling mode; the first one runs with the long hold-off
    random_mode(0, 0, 1'b1);
    random_mode(73, 0, 1'b0);
    random_mode(0, 73, 1'b0);
    random_mode(11, 11, 1'b0);

    // Bright pixels push the low Adler sum past its modulus within one frame
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(REG_IMAGE_WIDTH, 13'd22);
    write_reg(REG_IMAGE_HEIGHT, 13'd4);
    repeat (88) pending_pixels.push_back({8'($urandom), 24'hFFFFFF});
    settle();

    // Largest header: both registers all ones, hundreds of stored blocks in the
    // IDAT length, frame left open after a few pixels
    write_reg(REG_IMAGE_WIDTH, 13'h1FFF);
    write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
    queue_random(5);
    settle();

    $display("covered %0d pixels in %0d closed frames, %0d file bytes compared",
             pixels_taken, frames_closed, bytes_seen);
    $display("saturated, spare and extreme sizes, multi-block header, hold-off; %0d mismatches",
             error_count);
    if (error_count == 0 && png_expect.size() == 0)
      $display("PASS rgb_frame_to_stored_png_stream_core");
    else
      $display("FAIL rgb_frame_to_stored_png_stream_core");
    $finish;
  end

endmodule
